/* hdl/rsc_pkg.sv */
// shared types, constants and helpers for the radix string converter
// no dependencies; imported by every module of the block
`default_nettype none

package rsc_pkg;

   localparam int VALUE_WIDTH = 31;   // width of the value field on the input stream
   localparam int RADIX_BITS  = 5;
   localparam int DIGIT_BITS  = 4;
   localparam int CHAR_BITS   = 7;
   localparam int STEP_BITS   = 8;    // quotient bits resolved per divider cycle

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

   localparam logic [DIGIT_BITS-1:0] DIGIT_MAX_DEC = 4'd9;
   localparam logic [CHAR_BITS-1:0]  ASCII_ZERO    = 7'h30;   // '0'
   localparam logic [CHAR_BITS-1:0]  ASCII_ALPHA   = 7'h37;   // 'A' minus ten
   localparam logic [CHAR_BITS-1:0]  CHAR_ERROR    = 7'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_SHOW
   } rsc_state_type;

   typedef struct packed {
      logic load;    // take a fresh dividend
      logic start;   // begin extracting one digit
   } rsc_div_ctrl_type;

   typedef struct packed {
      logic                  done;            // digit ready, one cycle pulse
      logic                  quotient_zero;   // quotient left after this digit is zero
      logic [DIGIT_BITS-1:0] digit;
   } rsc_div_stat_type;

   function automatic logic [CHAR_BITS-1:0] to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] base;
      base = (d <= DIGIT_MAX_DEC) ? ASCII_ZERO : ASCII_ALPHA;
      return base + CHAR_BITS'(d);
   endfunction

endpackage

`default_nettype wire

/* hdl/radix_string_converter.sv */
// sequence: each digit is split off in one pass of the shared divider,
// then each character is read from the buffer, then held until taken
// throughput: one value at a time, the next is taken once its last character has gone
// a base outside 2..16 gives one error transaction, offered the cycle after the value is taken
// reset: synchronous, active high; radix returns to 16, sequencer idles, buffer not cleared
// top level of the radix string converter; depends on rsc_pkg, rsc_div_unit, rsc_digit_store
`default_nettype none

module radix_string_converter
   import rsc_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [31:0]           req_tdata,   // [30:0] value, [31] zero fill
   // response stream
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [7:0]            rsp_tdata,   // [6:0] char_code, [7] zero fill
   output      logic                  rsp_tlast,   // last_char
   output      logic                  rsp_tuser,   // [0] status, 1 for bad base
   // radix register write channel
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [RADIX_BITS-1:0] csr_data
);

   // value bits that take part in the conversion
   localparam int USED_BITS = (VALUE_BITS < VALUE_WIDTH) ? VALUE_BITS : VALUE_WIDTH;
   localparam int AW        = $clog2(USED_BITS);
   localparam int CW        = $clog2(USED_BITS + 1);

   rsc_state_type         state_ff, state_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [CW-1:0]         count_ff, count_in;    // digits held in the buffer
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;  // digit being sent, counts down to zero
   logic                  err_ff, err_in;

   logic                  req_accept;
   logic                  rsp_accept;
   logic                  radix_ok;
   logic                  is_last;
   logic                  wr_en;
   logic                  rd_en;
   logic [DIGIT_BITS-1:0] rd_data;

   rsc_div_ctrl_type      div_ctrl;
   rsc_div_stat_type      div_stat;

   assign csr_ready  = 1'b1;
   assign radix_ok   = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign is_last    = err_ff || (rd_idx_ff == '0);

   // shared divider, one digit per pass
   rsc_div_unit #(
      .USED_BITS (USED_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (div_ctrl),
      .load_value (req_tdata[USED_BITS-1:0]),
      .radix      (radix_ff),
      .stat       (div_stat)
   );

   // remainders, least significant first
   rsc_digit_store #(
      .DEPTH (USED_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (div_stat.digit),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = radix_ok ? ST_DIVIDE : ST_SHOW;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done && div_stat.quotient_zero) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_accept) begin
               state_in = is_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      rsp_tvalid     = (state_ff == ST_SHOW);
      div_ctrl.load  = req_accept && radix_ok;
      div_ctrl.start = (req_accept && radix_ok) ||
                       ((state_ff == ST_DIVIDE) && div_stat.done && !div_stat.quotient_zero);
      wr_en          = (state_ff == ST_DIVIDE) && div_stat.done;
      rd_en          = (state_ff == ST_READ);
   end

   // bookkeeping registers
   always_comb begin
      radix_in  = radix_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      err_in    = err_ff;
      if (csr_valid && csr_ready) begin
         radix_in = csr_data;
      end
      if (req_accept) begin
         count_in = '0;
         err_in   = !radix_ok;
      end
      if (wr_en) begin
         // the digit just written is the most significant so far
         count_in  = count_ff + 1'b1;
         rd_idx_in = count_ff[AW-1:0];
      end
      if (rsp_accept && !is_last) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         count_ff <= '0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
   end

   // response transaction, digits mapped to ascii on the way out, a zero character for a bad base
   assign rsp_tdata = {1'b0, err_ff ? CHAR_ERROR : to_ascii(rd_data)};
   assign rsp_tlast = is_last;
   assign rsp_tuser = err_ff;

`ifndef NO_ASSERTIONS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response sides open together");

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CW'(USED_BITS)))
      else $error("digit written beyond the buffer");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_tdata == 8'h00)))
      else $error("error transaction not a single zero character");

   a_divider_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIVIDE) |-> !div_stat.done)
      else $error("divider finished outside the divide phase");

   a_read_then_show: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_SHOW))
      else $error("buffer read not followed by a response");
`endif

endmodule

`default_nettype wire

/* hdl/rsc_div_unit.sv */
// shared divider: splits one digit off the working quotient per pass
// depends on rsc_pkg; STEP_BITS restoring steps per cycle
`default_nettype none

module rsc_div_unit
   import rsc_pkg::*;
#(
   parameter int USED_BITS = 31
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rsc_div_ctrl_type      ctrl,
   input  wire logic [USED_BITS-1:0]  load_value,
   input  wire logic [RADIX_BITS-1:0] radix,
   output      rsc_div_stat_type      stat
);

   localparam int DIV_CYCLES = (USED_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS   = DIV_CYCLES * STEP_BITS;
   localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

   logic [PAD_BITS-1:0]   wq_ff, wq_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  last_step;
   logic [STEP_BITS-1:0]  qbits;

   assign last_step = (cnt_ff == CNT_W'(DIV_CYCLES - 1));

   // restoring division of the top slice, remainder stays below the radix
   always_comb begin
      logic [DIGIT_BITS:0]  r;
      logic [DIGIT_BITS:0]  t;
      logic [STEP_BITS-1:0] top;
      top   = wq_ff[PAD_BITS-1 -: STEP_BITS];
      r     = (cnt_ff == '0) ? '0 : {1'b0, rem_ff};
      qbits = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         t = {r[DIGIT_BITS-1:0], top[i]};
         if (t >= radix) begin
            r        = t - radix;
            qbits[i] = 1'b1;
         end else begin
            r = t;
         end
      end
      rem_in = r[DIGIT_BITS-1:0];
   end

   always_comb begin
      wq_in   = wq_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.load) begin
         wq_in = PAD_BITS'(load_value);
      end else if (busy_ff) begin
         wq_in = (wq_ff << STEP_BITS) | PAD_BITS'(qbits);
      end
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      wq_ff <= wq_in;
      if (busy_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign stat.done          = done_ff;
   assign stat.quotient_zero = (wq_ff == '0);
   assign stat.digit         = rem_ff;

endmodule

`default_nettype wire

/* hdl/rsc_digit_store.sv */
// digit buffer: one write port, one registered read port
// depends on rsc_pkg for the digit width
`default_nettype none

module rsc_digit_store
   import rsc_pkg::*;
#(
   parameter int DEPTH = 31
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DIGIT_BITS-1:0]    wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [DIGIT_BITS-1:0]    rd_data
);

   logic [DIGIT_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* test/radix_string_converter_tb.sv */
// self-checking testbench for radix_string_converter: directed and random conversions
// checked character by character against a behavioural predictor; depends on rsc_pkg and the rtl
`default_nettype none

module radix_string_converter_tb;
   import rsc_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 16;     // covers the error path and a character
   localparam int WATCHDOG_LIMIT = 5000;   // base 2 needs the most divider passes before its first character
   localparam int MAX_REPORTS    = 10;
   localparam int DECIMAL_DIGITS = 10;
   localparam int PHASE_ITEMS    = 84;
   localparam logic [7:0] ASC_DIGIT0 = "0";
   localparam logic [7:0] ASC_LETTER = "A";
   localparam logic [VALUE_WIDTH-1:0] VALUE_ALL_ONES = '1;

   // one expected or observed character transaction
   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last_char;
      logic                 status;
   } char_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;   // [30:0] value, [31] zero fill
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // [6:0] char_code, [7] zero fill
   logic                  rsp_tlast;        // last_char
   logic                  rsp_tuser;        // [0] status
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [RADIX_BITS-1:0] csr_data = '0;

   // predictor state and run bookkeeping
   logic [RADIX_BITS-1:0] radix_shadow = RADIX_RESET;
   char_result_type       pending_chars[$];
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_idle_pct = 0;
   int unsigned           mismatch_count = 0;
   int unsigned           items_sent = 0;
   int unsigned           chars_checked = 0;
   int unsigned           error_results = 0;
   int unsigned           radix_writes = 0;
   int unsigned           quiet_cycles = 0;

   radix_string_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // expected characters of one conversion, most significant digit first
   function automatic void predict_conversion(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] quotient;
      logic [DIGIT_BITS-1:0]  digits[$];
      char_result_type        item;
      if (radix_shadow < RADIX_MIN || radix_shadow > RADIX_MAX) begin
         // bad base: one flagged transaction, no digits
         item.char_code = CHAR_ERROR;
         item.last_char = 1'b1;
         item.status    = 1'b1;
         pending_chars.push_back(item);
         return;
      end
      quotient = value;
      // repeated division; zero still yields one digit
      do begin
         digits.push_front(DIGIT_BITS'(quotient % radix_shadow));
         quotient = quotient / radix_shadow;
      end while (quotient != 0);
      foreach (digits[k]) begin
         if (digits[k] < DECIMAL_DIGITS)
            item.char_code = CHAR_BITS'(ASC_DIGIT0 + digits[k]);
         else
            item.char_code = CHAR_BITS'(ASC_LETTER + digits[k] - DECIMAL_DIGITS);
         item.last_char = (k == digits.size() - 1);
         item.status    = 1'b0;
         pending_chars.push_back(item);
      end
   endfunction

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // response checker: each accepted character against the oldest expectation
   always @(posedge clock) begin
      char_result_type got;
      char_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.char_code = rsp_tdata[CHAR_BITS-1:0];
         got.last_char = rsp_tlast;
         got.status    = rsp_tuser;
         chars_checked++;
         if (got.status)
            error_results++;
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected character transaction: char %h last %b status %b",
                        $realtime, got.char_code, got.last_char, got.status);
         end else begin
            want = pending_chars.pop_front();
            if (got.char_code !== want.char_code || got.last_char !== want.last_char ||
                got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch: expected char %h last %b status %b",
                           $realtime, want.char_code, want.last_char, want.status);
                  $display("%0t:           got char %h last %b status %b",
                           $realtime, got.char_code, got.last_char, got.status);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d characters outstanding",
                  quiet_cycles, pending_chars.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one value transaction; valid stays high into the next call unless the sender idles
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, value};
      predict_conversion(value);
      items_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   // sender holds off until every expected character has come, then lets the block settle
   task automatic drain_converter();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // radix write, only ever issued with the converter idle
   task automatic write_radix(input logic [RADIX_BITS-1:0] radix);
      drain_converter();
      csr_valid <= 1'b1;
      csr_data  <= radix;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      radix_shadow = radix;
      radix_writes++;
   endtask

   // reset base of 16: extremes of the value and every hex digit
   task automatic test_hex_defaults();
      send_value('0);
      send_value(VALUE_WIDTH'(1));
      send_value(VALUE_WIDTH'(15));
      send_value(VALUE_WIDTH'(16));
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_WIDTH'(32'h4000_0000));
      send_value(VALUE_WIDTH'(32'h0123_4567));
      send_value(VALUE_WIDTH'(32'h789A_BCDE));
   endtask

   // smallest and other valid bases, including the longest string
   task automatic test_valid_bases();
      write_radix(RADIX_MIN);
      send_value('0);
      send_value(VALUE_WIDTH'(1));
      send_value(VALUE_ALL_ONES);                   // 31 characters
      send_value(VALUE_WIDTH'(32'h2AAA_AAAA));
      write_radix(5'd10);
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_WIDTH'(DECIMAL_DIGITS));
      write_radix(5'd3);
      send_value(VALUE_ALL_ONES);
      write_radix(RADIX_MAX);
   endtask

   // bases below 2 and above 16 give a single flagged transaction
   task automatic test_bad_bases();
      write_radix(5'd0);
      send_value(VALUE_ALL_ONES);
      write_radix(5'd1);
      send_value(VALUE_WIDTH'(32'h1234_5678));
      write_radix(RADIX_MAX + 5'd1);
      send_value('0);
      write_radix('1);
      send_value(VALUE_WIDTH'(32'h5555_5555));
   endtask

   // random values of random length, base redrawn every so often
   task automatic test_random_values(input int unsigned send_pct, input int unsigned recv_pct);
      int unsigned            span;
      logic [VALUE_WIDTH-1:0] value;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % 21 == 0) begin
            // mostly legal bases, now and then anything the register holds
            if ($urandom_range(0, 99) < 85)
               write_radix(RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX)));
            else
               write_radix(RADIX_BITS'($urandom_range(0, 31)));
         end
         span  = $urandom_range(1, VALUE_WIDTH);
         value = VALUE_WIDTH'($urandom) & VALUE_WIDTH'((64'd1 << span) - 1);
         send_value(value);
      end
   endtask

   initial begin
      send_idle_pct = 32;
      recv_idle_pct = 56;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hex_defaults();
      test_valid_bases();
      test_bad_bases();
      test_random_values(32, 56);
      test_random_values(56, 32);
      test_random_values(0, 0);
      drain_converter();

      $display("covered %0d values and %0d characters (%0d flagged) over %0d radix writes",
               items_sent, chars_checked, error_results, radix_writes);
      $display("legal and illegal bases incl. extremes, idle mixes on both streams, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
